>>> design/lpdf_pkg.sv
// Shared constants for the lidar packet deframer.
package lpdf_pkg;

    localparam int PACKET_BYTES        = 42;
    localparam int PACKETS_PER_SCAN    = 60;
    localparam int READINGS_PER_PACKET = 6;

    localparam logic [7:0] SYNC_BYTE   = 8'hFA;
    localparam logic [7:0] FIRST_INDEX = 8'hA0;

    localparam int READING_BYTES  = 6;
    localparam int READINGS_START = 4;
    localparam int SPEED_LO_OFF   = 2;
    localparam int SPEED_HI_OFF   = 3;
    localparam int RANGE_LO_BYTE  = 2;
    localparam int RANGE_HI_BYTE  = 3;

    localparam int OFF_W     = 6;
    localparam int OFF_W_P1  = OFF_W + 1;
    localparam int PKT_NUM_W = 6;
    localparam int RD_IDX_W  = $clog2(READINGS_PER_PACKET + 1);
    localparam int RD_BYTE_W = 3;
    localparam int SLOT_W    = 10;
    localparam int ANGLE_W   = 9;
    localparam int RANGE_W   = 16;
    localparam int SPEED_W   = 16;

    localparam int TOTAL_SLOTS = PACKETS_PER_SCAN * READINGS_PER_PACKET;

    localparam int M_TDATA_W = 48;

endpackage

>>> design/lidar_packet_deframer_unit.sv
// Byte-serial deframer that turns sensor packets into range readings.
// A result word is registered and appears on the master side in the cycle after the byte that completes it.
// Throughput: one byte per cycle unless a pending result is stalled, set by the parse state registers updated per byte.
// The result register lets a new byte be taken in the cycle the pending result is taken.
// Reset is synchronous and active low; it returns the parser to sync hunting with no scan
// active and empties the result register.
module lidar_packet_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // rx_byte[7:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [lpdf_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
        // angle_index[8:0], range_value[24:9], rotor_rate[40:25], zero[47:41]
    output logic        o_m_axis_tuser    // scan_start[0]
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC,
        PH_BODY
    } t_phase;

    t_phase r_phase, n_phase;
    logic [lpdf_pkg::OFF_W-1:0]     r_offset, n_offset;
    logic [lpdf_pkg::PKT_NUM_W-1:0] r_pkt_num, n_pkt_num;
    logic [lpdf_pkg::PKT_NUM_W-1:0] r_last_num, n_last_num;
    logic                           r_scan_active, n_scan_active;
    logic                           r_pkt_ok, n_pkt_ok;
    logic [7:0]                     r_range_lo, n_range_lo;
    logic [lpdf_pkg::SPEED_W-1:0]   r_speed, n_speed;
    logic [lpdf_pkg::RD_IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic [lpdf_pkg::RD_BYTE_W-1:0] r_rd_byte, n_rd_byte;

    logic                           r_m_valid, n_m_valid;
    logic [lpdf_pkg::ANGLE_W-1:0]   r_m_angle, n_m_angle;
    logic [lpdf_pkg::RANGE_W-1:0]   r_m_range, n_m_range;
    logic [lpdf_pkg::SPEED_W-1:0]   r_m_speed, n_m_speed;
    logic                           r_m_scan_start, n_m_scan_start;

    logic                           s_accept;
    logic                           made;
    logic [7:0]                     idx_diff;
    logic [lpdf_pkg::OFF_W_P1-1:0]  off_next;
    logic [lpdf_pkg::SLOT_W-1:0]    slot;
    logic [lpdf_pkg::SLOT_W-1:0]    slot_rev;

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign idx_diff = i_s_axis_tdata - lpdf_pkg::FIRST_INDEX;
    assign off_next = {1'b0, r_offset} + lpdf_pkg::OFF_W_P1'(1);
    assign slot     = lpdf_pkg::SLOT_W'(r_pkt_num)
                    * lpdf_pkg::SLOT_W'(lpdf_pkg::READINGS_PER_PACKET)
                    + lpdf_pkg::SLOT_W'(r_rd_idx);
    assign slot_rev = lpdf_pkg::SLOT_W'(lpdf_pkg::TOTAL_SLOTS - 1) - slot;

    always_comb begin
        n_phase       = r_phase;
        n_offset      = r_offset;
        n_pkt_num     = r_pkt_num;
        n_last_num    = r_last_num;
        n_scan_active = r_scan_active;
        n_pkt_ok      = r_pkt_ok;
        n_range_lo    = r_range_lo;
        n_speed       = r_speed;
        n_rd_idx      = r_rd_idx;
        n_rd_byte     = r_rd_byte;
        made          = 1'b0;

        if (s_accept) begin
            unique case (r_phase)
                PH_SYNC: begin
                    if (i_s_axis_tdata < lpdf_pkg::FIRST_INDEX ||
                        idx_diff >= 8'(lpdf_pkg::PACKETS_PER_SCAN)) begin
                        n_phase = (i_s_axis_tdata == lpdf_pkg::SYNC_BYTE) ? PH_SYNC : PH_HUNT;
                    end else begin
                        n_pkt_num = idx_diff[lpdf_pkg::PKT_NUM_W-1:0];
                        if (idx_diff == 8'd0) begin
                            n_scan_active = 1'b1;
                            n_last_num    = '0;
                            n_pkt_ok      = 1'b1;
                        end else if (r_scan_active &&
                                     idx_diff > {2'b00, r_last_num}) begin
                            n_last_num = idx_diff[lpdf_pkg::PKT_NUM_W-1:0];
                            n_pkt_ok   = 1'b1;
                        end else begin
                            n_pkt_ok = 1'b0;
                        end
                        n_phase   = PH_BODY;
                        n_offset  = lpdf_pkg::OFF_W'(lpdf_pkg::SPEED_LO_OFF);
                        n_rd_idx  = '0;
                        n_rd_byte = '0;
                    end
                end
                PH_BODY: begin
                    if (r_offset == lpdf_pkg::OFF_W'(lpdf_pkg::SPEED_LO_OFF)) begin
                        n_speed = {r_speed[15:8], i_s_axis_tdata};
                    end else if (r_offset == lpdf_pkg::OFF_W'(lpdf_pkg::SPEED_HI_OFF)) begin
                        n_speed = {i_s_axis_tdata, r_speed[7:0]};
                    end else if (r_offset >= lpdf_pkg::OFF_W'(lpdf_pkg::READINGS_START) &&
                                 r_rd_idx < lpdf_pkg::RD_IDX_W'(lpdf_pkg::READINGS_PER_PACKET)) begin
                        if (r_rd_byte == lpdf_pkg::RD_BYTE_W'(lpdf_pkg::RANGE_LO_BYTE)) begin
                            n_range_lo = i_s_axis_tdata;
                        end else if (r_rd_byte == lpdf_pkg::RD_BYTE_W'(lpdf_pkg::RANGE_HI_BYTE)) begin
                            made = r_pkt_ok;
                        end
                        if (r_rd_byte == lpdf_pkg::RD_BYTE_W'(lpdf_pkg::READING_BYTES - 1)) begin
                            n_rd_byte = '0;
                            n_rd_idx  = r_rd_idx + lpdf_pkg::RD_IDX_W'(1);
                        end else begin
                            n_rd_byte = r_rd_byte + lpdf_pkg::RD_BYTE_W'(1);
                        end
                    end
                    if (off_next >= lpdf_pkg::OFF_W_P1'(lpdf_pkg::PACKET_BYTES)) begin
                        n_phase  = PH_HUNT;
                        n_offset = '0;
                    end else begin
                        n_offset = off_next[lpdf_pkg::OFF_W-1:0];
                    end
                end
                default: begin
                    n_phase  = (i_s_axis_tdata == lpdf_pkg::SYNC_BYTE) ? PH_SYNC : PH_HUNT;
                    n_offset = '0;
                end
            endcase
        end
    end

    always_comb begin
        n_m_angle      = r_m_angle;
        n_m_range      = r_m_range;
        n_m_speed      = r_m_speed;
        n_m_scan_start = r_m_scan_start;
        if (made) begin
            n_m_valid      = 1'b1;
            n_m_angle      = slot_rev[lpdf_pkg::ANGLE_W-1:0];
            n_m_range      = {i_s_axis_tdata, r_range_lo};
            n_m_speed      = r_speed;
            n_m_scan_start = (r_pkt_num == '0) && (r_rd_idx == '0);
        end else if (i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_offset       <= '0;
            r_pkt_num      <= '0;
            r_last_num     <= '0;
            r_scan_active  <= 1'b0;
            r_pkt_ok       <= 1'b0;
            r_range_lo     <= '0;
            r_speed        <= '0;
            r_rd_idx       <= '0;
            r_rd_byte      <= '0;
            r_m_valid      <= 1'b0;
            r_m_angle      <= '0;
            r_m_range      <= '0;
            r_m_speed      <= '0;
            r_m_scan_start <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_offset       <= n_offset;
            r_pkt_num      <= n_pkt_num;
            r_last_num     <= n_last_num;
            r_scan_active  <= n_scan_active;
            r_pkt_ok       <= n_pkt_ok;
            r_range_lo     <= n_range_lo;
            r_speed        <= n_speed;
            r_rd_idx       <= n_rd_idx;
            r_rd_byte      <= n_rd_byte;
            r_m_valid      <= n_m_valid;
            r_m_angle      <= n_m_angle;
            r_m_range      <= n_m_range;
            r_m_speed      <= n_m_speed;
            r_m_scan_start <= n_m_scan_start;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {
        (lpdf_pkg::M_TDATA_W - lpdf_pkg::ANGLE_W - lpdf_pkg::RANGE_W - lpdf_pkg::SPEED_W)'(0),
        r_m_speed, r_m_range, r_m_angle
    };
    assign o_m_axis_tuser  = r_m_scan_start;

`ifndef NO_ASSERTIONS
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input word accepted while a result is stalled");

    a_offset_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |->
        (r_offset >= lpdf_pkg::OFF_W'(lpdf_pkg::SPEED_LO_OFF) &&
         r_offset < lpdf_pkg::OFF_W'(lpdf_pkg::PACKET_BYTES)))
        else $error("packet offset outside the packet body");

    a_scan_start_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_scan_start) |->
        (r_m_angle == lpdf_pkg::ANGLE_W'(lpdf_pkg::TOTAL_SLOTS - 1)))
        else $error("scan start word not in the first scan slot");

    a_result_needs_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (made) |-> (r_phase == PH_BODY && r_pkt_ok))
        else $error("result produced outside an accepted packet");
`endif

endmodule

>>> verif/tb_lidar_packet_deframer_unit.sv
// Self-checking testbench for the lidar packet deframer with stream stimulus and a checker.
`timescale 1ns / 100ps

module tb_lidar_packet_deframer_unit;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SYNC,
        PH_BODY
    } t_parse_phase;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_SYNC
    } t_payload_fill;

    typedef struct {
        logic [7:0] rx_byte;
        bit         wait_drain;
    } t_rx_word;

    typedef struct packed {
        logic [lpdf_pkg::ANGLE_W-1:0] angle;
        logic [lpdf_pkg::RANGE_W-1:0] range_val;
        logic [lpdf_pkg::SPEED_W-1:0] speed;
        logic                         scan_start;
    } t_reading;

    localparam int STIM_WORDS = 1850;
    localparam int DRAIN_SPACING = 600;
    localparam int HOLD_CYCLES = 300;
    localparam int END_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic m_tready = 1'b0;
    logic o_s_axis_tready;
    logic o_m_axis_tvalid;
    logic [lpdf_pkg::M_TDATA_W-1:0] o_m_axis_tdata;
    logic o_m_axis_tuser;

    t_rx_word rx_queue[$];
    t_reading readings_due[$];
    int next_drain_at = DRAIN_SPACING;
    int mismatches = 0;
    int readings_seen = 0;

    // Shadow of the parser state.
    t_parse_phase ph = PH_HUNT;
    logic [lpdf_pkg::OFF_W-1:0] pkt_off = '0;
    logic [lpdf_pkg::PKT_NUM_W-1:0] pkt_num = '0;
    logic [lpdf_pkg::PKT_NUM_W-1:0] last_num = '0;
    logic scan_on = 1'b0;
    logic pkt_taken = 1'b0;
    logic [7:0] range_lo = 8'h00;
    logic [lpdf_pkg::SPEED_W-1:0] speed_word = '0;

    lidar_packet_deframer_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic predict_byte(input logic [7:0] b);
        int n;
        int d;
        int r;
        int k;
        int slot;
        t_reading res;
        case (ph)
            PH_SYNC: begin
                n = int'(b) - int'(lpdf_pkg::FIRST_INDEX);
                if (n < 0 || n >= lpdf_pkg::PACKETS_PER_SCAN) begin
                    ph = (b == lpdf_pkg::SYNC_BYTE) ? PH_SYNC : PH_HUNT;
                end else begin
                    pkt_num = lpdf_pkg::PKT_NUM_W'(n);
                    if (n == 0) begin
                        scan_on = 1'b1;
                        last_num = '0;
                        pkt_taken = 1'b1;
                    end else if (scan_on && n > int'(last_num)) begin
                        last_num = lpdf_pkg::PKT_NUM_W'(n);
                        pkt_taken = 1'b1;
                    end else begin
                        pkt_taken = 1'b0;
                    end
                    ph = PH_BODY;
                    pkt_off = lpdf_pkg::OFF_W'(2);
                end
            end
            PH_BODY: begin
                if (pkt_off == lpdf_pkg::SPEED_LO_OFF) begin
                    speed_word[7:0] = b;
                end else if (pkt_off == lpdf_pkg::SPEED_HI_OFF) begin
                    speed_word[15:8] = b;
                end else if (int'(pkt_off) >= lpdf_pkg::READINGS_START) begin
                    d = int'(pkt_off) - lpdf_pkg::READINGS_START;
                    r = d / lpdf_pkg::READING_BYTES;
                    k = d % lpdf_pkg::READING_BYTES;
                    if (r < lpdf_pkg::READINGS_PER_PACKET) begin
                        if (k == lpdf_pkg::RANGE_LO_BYTE) begin
                            range_lo = b;
                        end else if (k == lpdf_pkg::RANGE_HI_BYTE && pkt_taken) begin
                            slot = int'(pkt_num) * lpdf_pkg::READINGS_PER_PACKET + r;
                            res.angle = lpdf_pkg::ANGLE_W'(lpdf_pkg::TOTAL_SLOTS - 1 - slot);
                            res.range_val = {b, range_lo};
                            res.speed = speed_word;
                            res.scan_start = (pkt_num == 0 && r == 0);
                            readings_due.push_back(res);
                        end
                    end
                end
                if (int'(pkt_off) + 1 >= lpdf_pkg::PACKET_BYTES) begin
                    ph = PH_HUNT;
                    pkt_off = '0;
                end else begin
                    pkt_off = pkt_off + 1'b1;
                end
            end
            default: begin
                ph = (b == lpdf_pkg::SYNC_BYTE) ? PH_SYNC : PH_HUNT;
                pkt_off = '0;
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_rx_word w;
        w.rx_byte = b;
        w.wait_drain = 1'b0;
        if (rx_queue.size() >= next_drain_at) begin
            w.wait_drain = 1'b1;
            next_drain_at += DRAIN_SPACING;
        end
        rx_queue.push_back(w);
    endtask

    function automatic logic [7:0] payload_byte(input t_payload_fill fill);
        logic [7:0] b;
        case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            FILL_SYNC: b = lpdf_pkg::SYNC_BYTE;
            default: begin
                case ($urandom_range(0, 15))
                    0: b = lpdf_pkg::SYNC_BYTE;
                    1: b = 8'h00;
                    2: b = 8'hFF;
                    3: b = lpdf_pkg::FIRST_INDEX;
                    default: b = 8'($urandom);
                endcase
            end
        endcase
        return b;
    endfunction

    task automatic push_packet(input int num, input t_payload_fill fill);
        push_byte(lpdf_pkg::SYNC_BYTE);
        push_byte(lpdf_pkg::FIRST_INDEX + 8'(num));
        for (int i = 2; i < lpdf_pkg::PACKET_BYTES; i++) begin
            push_byte(payload_byte(fill));
        end
    endtask

    task automatic push_noise();
        case ($urandom_range(0, 3))
            0: push_byte(8'($urandom));
            1: begin
                push_byte(lpdf_pkg::SYNC_BYTE);
                push_byte(8'($urandom_range(0, 8'h9F)));
            end
            2: begin
                push_byte(lpdf_pkg::SYNC_BYTE);
                push_byte(8'($urandom_range(8'hDC, 8'hFF)));
            end
            default: begin
                push_byte(lpdf_pkg::SYNC_BYTE);
                push_byte(lpdf_pkg::SYNC_BYTE);
            end
        endcase
    endtask

    task automatic build_stimulus();
        int goal;
        int num;
        int last;
        // Stray bytes and broken index bytes, including a sync byte in the index position.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(lpdf_pkg::SYNC_BYTE);
        push_byte(lpdf_pkg::FIRST_INDEX - 8'd1);
        push_byte(lpdf_pkg::SYNC_BYTE);
        push_byte(lpdf_pkg::FIRST_INDEX + 8'(lpdf_pkg::PACKETS_PER_SCAN));
        push_byte(lpdf_pkg::SYNC_BYTE);
        push_byte(lpdf_pkg::SYNC_BYTE);
        push_byte(8'hFF);
        // A packet before any scan start is skipped.
        push_packet(5, FILL_RANDOM);
        push_packet(0, FILL_ZERO);
        push_packet(1, FILL_ONES);
        // Repeated and lower indexes are skipped.
        push_packet(1, FILL_RANDOM);
        push_packet(3, FILL_RANDOM);
        push_packet(2, FILL_RANDOM);
        // Sync bytes all through the payload of the highest packet.
        push_packet(lpdf_pkg::PACKETS_PER_SCAN - 1, FILL_SYNC);
        push_packet(0, FILL_RANDOM);
        push_packet(lpdf_pkg::PACKETS_PER_SCAN - 1, FILL_RANDOM);

        goal = STIM_WORDS;
        next_drain_at = rx_queue.size();
        while (rx_queue.size() < goal) begin
            num = 0;
            last = 0;
            if ($urandom_range(0, 7) != 0) begin
                push_packet(0, FILL_RANDOM);
            end
            while (num < lpdf_pkg::PACKETS_PER_SCAN && rx_queue.size() < goal) begin
                if ($urandom_range(0, 3) == 0) begin
                    push_noise();
                end
                if ($urandom_range(0, 9) == 0) begin
                    push_packet($urandom_range(0, last), FILL_RANDOM);
                end else begin
                    num += $urandom_range(1, 8);
                    if (num < lpdf_pkg::PACKETS_PER_SCAN) begin
                        push_packet(num, FILL_RANDOM);
                        last = num;
                    end else if ($urandom_range(0, 1) == 0) begin
                        push_packet(lpdf_pkg::PACKETS_PER_SCAN - 1, FILL_RANDOM);
                    end
                end
            end
        end
    endtask

    // Sender: bursts of random length with random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !o_s_axis_tready)) begin
            if (s_tvalid) begin
                predict_byte(rx_queue[0].rx_byte);
                void'(rx_queue.pop_front());
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (rx_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (rx_queue[0].wait_drain && readings_due.size() != 0) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= rx_queue[0].rx_byte;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Receiver: random stall modes, plus two long hold-offs.
    int hold_left = 0;
    int holds_done = 0;
    int mode = 0;
    int mode_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if ((holds_done == 0 && readings_seen >= 40) ||
                     (holds_done == 1 && readings_seen >= 150)) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 80);
            end else begin
                mode_left--;
            end
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            readings_seen++;
            if (readings_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result word, angle %0d",
                                          o_m_axis_tdata[8:0]));
            end else begin
                want = readings_due.pop_front();
                if (o_m_axis_tdata[8:0] !== want.angle)
                    report_mismatch($sformatf("mismatch on angle_index: got %0d, expected %0d",
                                              o_m_axis_tdata[8:0], want.angle));
                if (o_m_axis_tdata[24:9] !== want.range_val)
                    report_mismatch($sformatf("mismatch on range_value: got %0d, expected %0d",
                                              o_m_axis_tdata[24:9], want.range_val));
                if (o_m_axis_tdata[40:25] !== want.speed)
                    report_mismatch($sformatf("mismatch on rotor_rate: got %0d, expected %0d",
                                              o_m_axis_tdata[40:25], want.speed));
                if (o_m_axis_tuser !== want.scan_start)
                    report_mismatch($sformatf("mismatch on scan_start: got %0d, expected %0d",
                                              o_m_axis_tuser, want.scan_start));
            end
        end
    end

    initial begin
        build_stimulus();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (rx_queue.size() != 0 || s_tvalid || readings_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (END_CYCLES) @(posedge i_clk);
        if (readings_due.size() != 0) begin
            report_mismatch($sformatf("%0d result words never arrived", readings_due.size()));
        end
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout waiting for result words");
        $display("Some tests failed");
        $finish;
    end

endmodule
